[rtl/core/tfb_pkg.sv]
package tfb_pkg;

  // Frame geometry
  localparam int unsigned BodyLen  = 35;
  localparam int unsigned FrameLen = 37;
  localparam int unsigned IdxW     = 6;

  localparam logic [IdxW-1:0] IdxCrcLo = 6'd35;
  localparam logic [IdxW-1:0] IdxLast  = 6'd36;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMagic   = 2'd0,
    CfgVersion = 2'd1,
    CfgType    = 2'd2
  } tfb_cfg_idx_e;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [15:0] format_version;
    logic [15:0] frame_type;
  } tfb_cfg_t;

  // One health record, first field in the high bits
  typedef struct packed {
    logic [31:0] heartbeats;
    logic [31:0] mem_load_bits;
    logic [31:0] cpu_load_bits;
    logic [15:0] fault_id;
    logic [7:0]  op_mode;
    logic [63:0] time_ms;
    logic [31:0] sequence_req;
  } tfb_rec_t;

  // Handshake between the record queue and the serializer
  typedef struct packed {
    logic     valid;
    tfb_rec_t rec;
  } tfb_fwd_t;

  // Advance the CRC over one byte, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

[rtl/core/tfb_front.sv]
module tfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  tfb_pkg::tfb_rec_t rec_i,
  output tfb_pkg::tfb_fwd_t fwd_o,
  input  logic              fwd_ready_i
);
  import tfb_pkg::*;

  tfb_rec_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = fwd_o.valid && fwd_ready_i;

  assign fwd_o.valid = (cnt_q != 2'd0);
  assign fwd_o.rec   = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the accepted record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

[rtl/core/tfb_back.sv]
module tfb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfb_pkg::tfb_cfg_t cfg_i,
  input  tfb_pkg::tfb_fwd_t fwd_i,
  output logic              fwd_ready_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              is_last_o
);
  import tfb_pkg::*;

  tfb_rec_t              rec_q;
  logic                  busy_q, busy_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [15:0]           crc_q, crc_d;
  logic                  out_vld_q, out_vld_d;
  logic [7:0]            out_byte_q;
  logic                  out_last_q;
  logic [8*BodyLen-1:0]  body;
  logic [7:0]            cur_byte;
  logic                  adv, at_last, load;

  assign body = {rec_q, cfg_i.frame_type, cfg_i.format_version, cfg_i.frame_magic};

  // Pick the byte at the current position
  always_comb begin
    if (idx_q == IdxCrcLo) begin
      cur_byte = crc_q[7:0];
    end else if (idx_q == IdxLast) begin
      cur_byte = crc_q[15:8];
    end else begin
      cur_byte = body[8*idx_q +: 8];
    end
  end

  assign adv         = busy_q && (!out_vld_q || pop_i);
  assign at_last     = (idx_q == IdxLast);
  assign load        = fwd_i.valid && (!busy_q || (adv && at_last));
  assign fwd_ready_o = load;

  // Step through the frame, reload on the last byte
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
      crc_d  = CrcInit;
    end else if (adv) begin
      if (at_last) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + 6'd1;
      if (idx_q < IdxCrcLo) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
    end
  end

  // Hold a byte until it is taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (load) begin
      rec_q <= fwd_i.rec;
    end
    if (adv) begin
      out_byte_q <= cur_byte;
      out_last_q <= at_last;
    end
  end

  assign empty_o    = !out_vld_q;
  assign out_byte_o = out_byte_q;
  assign is_last_o  = out_last_q;

endmodule

[rtl/core/telemetry_frame_builder_crc16_unit.sv]
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// record in | push / full          | sequence_req .. heartbeats (216 bits)
// frame out | empty / pop          | out_byte (8), is_last (1)
// config    | cfg_valid / ready    | cfg_index (2), cfg_data (32)
//
// Each record becomes 37 bytes, one per cycle while pop takes them; frames
// run back to back if a record waits. A two-entry record queue decouples
// intake from the serializer. The first byte passes the queue, the record
// register and the output register; the CRC takes one byte per cycle while
// bytes advance. Reset clears control state and the configuration registers.
// Stalls on pop hold the current byte; intake stalls only when the queue fills.
module telemetry_frame_builder_crc16_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [31:0]                   sequence_req_i,
  input  logic [63:0]                   time_ms_i,
  input  logic [7:0]                    op_mode_i,
  input  logic [15:0]                   fault_id_i,
  input  logic [31:0]                   cpu_load_bits_i,
  input  logic [31:0]                   mem_load_bits_i,
  input  logic [31:0]                   heartbeats_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte_o,
  output logic                          is_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tfb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tfb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tfb_pkg::*;

  tfb_cfg_t cfg_q;
  tfb_rec_t rec_in;
  tfb_fwd_t fwd;
  logic     fwd_ready;
  logic     cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Decode configuration writes, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CfgMagic:   cfg_q.frame_magic    <= cfg_data_i;
        CfgVersion: cfg_q.format_version <= cfg_data_i[15:0];
        CfgType:    cfg_q.frame_type     <= cfg_data_i[15:0];
        default:    ;
      endcase
    end
  end

  assign rec_in.sequence_req  = sequence_req_i;
  assign rec_in.time_ms       = time_ms_i;
  assign rec_in.op_mode       = op_mode_i;
  assign rec_in.fault_id      = fault_id_i;
  assign rec_in.cpu_load_bits = cpu_load_bits_i;
  assign rec_in.mem_load_bits = mem_load_bits_i;
  assign rec_in.heartbeats    = heartbeats_i;

  tfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .rec_i       (rec_in),
    .fwd_o       (fwd),
    .fwd_ready_i (fwd_ready)
  );

  tfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fwd_i       (fwd),
    .fwd_ready_o (fwd_ready),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o  (out_byte_o),
    .is_last_o   (is_last_o)
  );

endmodule

[rtl/core/tfb_checker.sv]
module tfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       is_last_o
);

  // A waiting item stays until taken
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped without pop");

  // A waiting item keeps its value
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_byte_o) && $stable(is_last_o))
    else $error("result changed while stalled");

  // The queue only fills on an accepted push
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // An output item appears only after some record was pushed
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) && $past(empty, 2) |-> $past(push, 2) || $past(push, 3) || !$past(rst_ni, 3)
      || $past(full, 2) || !$past(empty, 3))
    else $error("result without a record");

endmodule

bind telemetry_frame_builder_crc16_unit tfb_checker u_tfb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte_o (out_byte_o),
  .is_last_o  (is_last_o)
);
